[rtl/core/tpa_pkg.sv]
// shared types, codes and helpers of the two-level page allocator
`default_nettype none
package tpa_pkg;

    localparam int MAP_WORD_MAX = 64;
    localparam int GRP_IDX_MAX_W = 10;

    typedef enum logic [2:0] {
        FN_ALLOC_PAGE = 3'd0,
        FN_FREE_PAGE  = 3'd1,
        FN_ALLOC_HUGE = 3'd2,
        FN_FREE_HUGE  = 3'd3,
        FN_ADD_REF    = 3'd4,
        FN_DROP_REF   = 3'd5,
        FN_ADD_HREF   = 3'd6,
        FN_NOP        = 3'd7
    } func_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NO_MEM    = 3'd1,
        ST_DBL_FREE  = 3'd2,
        ST_NOT_HUGE  = 3'd3,
        ST_UNDERFLOW = 3'd4,
        ST_SATURATED = 3'd5
    } status_t;

    typedef struct packed {
        logic                     part_hit;
        logic [GRP_IDX_MAX_W-1:0] part_grp;
        logic                     empty_hit;
        logic [GRP_IDX_MAX_W-1:0] empty_grp;
    } find_t;

    // index of the lowest set bit, zero when none
    function automatic logic [5:0] first_one64(input logic [MAP_WORD_MAX-1:0] w);
        logic [5:0] idx;
        idx = 6'd0;
        for (int i = MAP_WORD_MAX - 1; i >= 0; i--) begin
            if (w[i]) begin
                idx = 6'(i);
            end
        end
        return idx;
    endfunction

endpackage
`default_nettype wire

[rtl/core/tpa_ram.sv]
// generic single-write, single-read ram with registered read data
`default_nettype none
module tpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire                                 clk,
    input  wire                                 we,
    input  wire [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire [WIDTH-1:0]                     wdata,
    input  wire                                 re,
    input  wire [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                    rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end
endmodule
`default_nettype wire

[rtl/core/tpa_grp_find.sv]
// priority search for the lowest partly used and lowest empty group
`default_nettype none
module tpa_grp_find #(
    parameter int NUM_GROUPS = 64
) (
    input  wire [NUM_GROUPS-1:0] part_mask,
    input  wire [NUM_GROUPS-1:0] empty_mask,
    output tpa_pkg::find_t       found
);
    import tpa_pkg::*;

    always_comb
    begin
        found = '0;
        for (int g = NUM_GROUPS - 1; g >= 0; g--) begin
            if (part_mask[g]) begin
                found.part_hit = 1'b1;
                found.part_grp = GRP_IDX_MAX_W'(g);
            end
            if (empty_mask[g]) begin
                found.empty_hit = 1'b1;
                found.empty_grp = GRP_IDX_MAX_W'(g);
            end
        end
    end
endmodule
`default_nettype wire

[rtl/core/two_level_page_allocator_unit.sv]
// two-level page allocator: sequencer over the map, reference and group memories
//
//  channel | signals                                         | dir
//  in      | in_valid, in_ready, func, page_index, group_index | into block
//  out     | out_valid, out_ready, result_page, status,        | out of block
//          | free_pages, used_small, used_huge               |
//
// one item at a time: frees, reference operations and huge allocation go through the
// find, modify and done states; page allocation adds a scan of the group's free map,
// one word per cycle.
// after reset a clearing pass over all page addresses writes all memories;
// in_ready stays low meanwhile.
// a waiting result stalls only the finish of the next item.
`default_nettype none
module two_level_page_allocator_unit #(
    parameter int PAGES_PER_GROUP = 512,
    parameter int NUM_GROUPS      = 64,
    parameter int REF_WIDTH       = 8
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         in_valid,
    output logic        in_ready,
    input  wire  [2:0]  func,
    input  wire  [14:0] page_index,
    input  wire  [5:0]  group_index,
    output logic        out_valid,
    input  wire         out_ready,
    output logic [14:0] result_page,
    output logic [2:0]  status,
    output logic [15:0] free_pages,
    output logic [15:0] used_small,
    output logic [6:0]  used_huge
);
    import tpa_pkg::*;

    localparam int MAP_W  = (PAGES_PER_GROUP < MAP_WORD_MAX) ? PAGES_PER_GROUP : MAP_WORD_MAX;
    localparam int MB_W   = $clog2(MAP_W);
    localparam int WPG    = PAGES_PER_GROUP / MAP_W;
    localparam int WSH    = $clog2(WPG);
    localparam int WW     = (WPG > 1) ? $clog2(WPG) : 1;
    localparam int MAP_D  = NUM_GROUPS * WPG;
    localparam int MA_W   = (MAP_D > 1) ? $clog2(MAP_D) : 1;
    localparam int TOTAL  = PAGES_PER_GROUP * NUM_GROUPS;
    localparam int PA_W   = $clog2(TOTAL);
    localparam int PG_W   = $clog2(PAGES_PER_GROUP);
    localparam int GR_W   = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
    localparam int UW     = $clog2(PAGES_PER_GROUP + 1);
    localparam int CNT_W  = $clog2(TOTAL + 1);
    localparam int HC_W   = $clog2(NUM_GROUPS + 1);
    localparam logic [REF_WIDTH-1:0] REF_MAX = {REF_WIDTH{1'b1}};

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_FIND  = 6'b000100,
        S_SCAN  = 6'b001000,
        S_MOD   = 6'b010000,
        S_DONE  = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    func_t  func_reg, func_next;
    logic [PA_W-1:0]  page_reg, page_next;
    logic [PA_W-1:0]  rpage_reg, rpage_next;
    logic [GR_W-1:0]  grp_reg, grp_next;
    logic             pv_reg, pv_next;
    logic             gv_reg, gv_next;
    logic [WW-1:0]    word_reg, word_next;
    status_t          st_reg, st_next;
    logic [PA_W-1:0]  clr_reg, clr_next;
    logic [CNT_W-1:0] free_cnt_reg, free_cnt_next;
    logic [CNT_W-1:0] small_cnt_reg, small_cnt_next;
    logic [HC_W-1:0]  huge_cnt_reg, huge_cnt_next;
    logic [NUM_GROUPS-1:0] huge_vec_reg, huge_vec_next;
    logic [NUM_GROUPS-1:0] nz_vec_reg, nz_vec_next;
    logic [NUM_GROUPS-1:0] full_vec_reg, full_vec_next;
    logic             ov_reg, ov_next;
    logic [14:0]      o_page_reg, o_page_next;
    logic [2:0]       o_st_reg, o_st_next;
    logic [15:0]      o_free_reg, o_free_next;
    logic [15:0]      o_small_reg, o_small_next;
    logic [6:0]       o_huge_reg, o_huge_next;

    // memory ports
    logic map_we, map_re, pr_we, pr_re, gu_we, gu_re, gr_we, gr_re;
    logic [MA_W-1:0]      map_wa, map_ra;
    logic [MAP_W-1:0]     map_wd, map_rd;
    logic [PA_W-1:0]      pr_wa, pr_ra;
    logic [REF_WIDTH-1:0] pr_wd, pr_rd;
    logic [GR_W-1:0]      gu_wa, gu_ra, gr_wa, gr_ra;
    logic [UW-1:0]        gu_wd, gu_rd;
    logic [REF_WIDTH-1:0] gr_wd, gr_rd;

    find_t            found;
    logic [GR_W-1:0]  alloc_grp;
    logic [MAP_W-1:0] map_cur;
    logic [PA_W-1:0]  in_page;
    logic [MB_W-1:0]  bit_sel;
    logic [UW-1:0]    used_new;

    tpa_ram #(.WIDTH(MAP_W), .DEPTH(MAP_D)) u_map_ram (
        .clk(clk), .we(map_we), .waddr(map_wa), .wdata(map_wd),
        .re(map_re), .raddr(map_ra), .rdata(map_rd)
    );
    tpa_ram #(.WIDTH(REF_WIDTH), .DEPTH(TOTAL)) u_pref_ram (
        .clk(clk), .we(pr_we), .waddr(pr_wa), .wdata(pr_wd),
        .re(pr_re), .raddr(pr_ra), .rdata(pr_rd)
    );
    tpa_ram #(.WIDTH(UW), .DEPTH(NUM_GROUPS)) u_gused_ram (
        .clk(clk), .we(gu_we), .waddr(gu_wa), .wdata(gu_wd),
        .re(gu_re), .raddr(gu_ra), .rdata(gu_rd)
    );
    tpa_ram #(.WIDTH(REF_WIDTH), .DEPTH(NUM_GROUPS)) u_gref_ram (
        .clk(clk), .we(gr_we), .waddr(gr_wa), .wdata(gr_wd),
        .re(gr_re), .raddr(gr_ra), .rdata(gr_rd)
    );

    tpa_grp_find #(.NUM_GROUPS(NUM_GROUPS)) u_find (
        .part_mask (nz_vec_reg & ~full_vec_reg & ~huge_vec_reg),
        .empty_mask(~nz_vec_reg & ~huge_vec_reg),
        .found     (found)
    );

    assign alloc_grp = found.part_hit ? GR_W'(found.part_grp) : GR_W'(found.empty_grp);
    assign map_cur   = map_rd;
    assign in_page   = PA_W'(page_index);
    assign bit_sel   = page_reg[MB_W-1:0];

    assign in_ready    = (state_reg == S_IDLE);
    assign out_valid   = ov_reg;
    assign result_page = o_page_reg;
    assign status      = o_st_reg;
    assign free_pages  = o_free_reg;
    assign used_small  = o_small_reg;
    assign used_huge   = o_huge_reg;

    always_comb
    begin
        state_next     = state_reg;
        func_next      = func_reg;
        page_next      = page_reg;
        rpage_next     = rpage_reg;
        grp_next       = grp_reg;
        pv_next        = pv_reg;
        gv_next        = gv_reg;
        word_next      = word_reg;
        st_next        = st_reg;
        clr_next       = clr_reg;
        free_cnt_next  = free_cnt_reg;
        small_cnt_next = small_cnt_reg;
        huge_cnt_next  = huge_cnt_reg;
        huge_vec_next  = huge_vec_reg;
        nz_vec_next    = nz_vec_reg;
        full_vec_next  = full_vec_reg;
        ov_next        = ov_reg;
        o_page_next    = o_page_reg;
        o_st_next      = o_st_reg;
        o_free_next    = o_free_reg;
        o_small_next   = o_small_reg;
        o_huge_next    = o_huge_reg;
        used_new       = '0;

        map_we = 1'b0; map_re = 1'b0; map_wa = '0; map_ra = '0; map_wd = '0;
        pr_we  = 1'b0; pr_re  = 1'b0; pr_wa  = '0; pr_ra  = '0; pr_wd  = '0;
        gu_we  = 1'b0; gu_re  = 1'b0; gu_wa  = '0; gu_ra  = '0; gu_wd  = '0;
        gr_we  = 1'b0; gr_re  = 1'b0; gr_wa  = '0; gr_ra  = '0; gr_wd  = '0;

        if (ov_reg && out_ready) begin
            ov_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR:
            begin
                pr_we = 1'b1;
                pr_wa = clr_reg;
                pr_wd = '0;
                if (32'(clr_reg) < MAP_D) begin
                    map_we = 1'b1;
                    map_wa = MA_W'(clr_reg);
                    map_wd = '1;
                end
                if (32'(clr_reg) < NUM_GROUPS) begin
                    gu_we = 1'b1;
                    gu_wa = GR_W'(clr_reg);
                    gu_wd = '0;
                    gr_we = 1'b1;
                    gr_wa = GR_W'(clr_reg);
                    gr_wd = '0;
                end
                clr_next = clr_reg + 1'b1;
                if (32'(clr_reg) == TOTAL - 1) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid) begin
                    func_next  = func_t'(func);
                    page_next  = in_page;
                    pv_next    = (32'(page_index) < TOTAL);
                    gv_next    = (32'(group_index) < NUM_GROUPS);
                    grp_next   = GR_W'(group_index);
                    rpage_next = '0;
                    st_next    = ST_OK;
                    state_next = S_FIND;
                end
            end
            S_FIND:
            begin
                state_next = S_MOD;
                case (func_reg)
                    FN_ALLOC_PAGE:
                    begin
                        if (!found.part_hit && !found.empty_hit) begin
                            st_next    = ST_NO_MEM;
                            state_next = S_DONE;
                        end else begin
                            grp_next   = alloc_grp;
                            word_next  = '0;
                            map_re     = 1'b1;
                            map_ra     = MA_W'(alloc_grp) << WSH;
                            state_next = S_SCAN;
                        end
                    end
                    FN_FREE_PAGE:
                    begin
                        grp_next = GR_W'(page_reg >> PG_W);
                        map_re   = 1'b1;
                        map_ra   = MA_W'(page_reg >> MB_W);
                        pr_re    = 1'b1;
                        pr_ra    = page_reg;
                        gu_re    = 1'b1;
                        gu_ra    = GR_W'(page_reg >> PG_W);
                        if (!pv_reg) begin
                            state_next = S_DONE;
                        end
                    end
                    FN_ALLOC_HUGE:
                    begin
                        grp_next = GR_W'(found.empty_grp);
                        gr_re    = 1'b1;
                        gr_ra    = GR_W'(found.empty_grp);
                        if (!found.empty_hit) begin
                            st_next    = ST_NO_MEM;
                            state_next = S_DONE;
                        end
                    end
                    FN_FREE_HUGE, FN_ADD_HREF:
                    begin
                        gr_re = 1'b1;
                        gr_ra = grp_reg;
                        if (!gv_reg) begin
                            state_next = S_DONE;
                        end else if (func_reg == FN_FREE_HUGE && !huge_vec_reg[grp_reg]) begin
                            st_next    = ST_NOT_HUGE;
                            state_next = S_DONE;
                        end
                    end
                    FN_ADD_REF, FN_DROP_REF:
                    begin
                        pr_re = 1'b1;
                        pr_ra = page_reg;
                        if (!pv_reg) begin
                            state_next = S_DONE;
                        end
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_SCAN:
            begin
                if (map_cur != '0) begin
                    page_next = (PA_W'(grp_reg) << PG_W) + (PA_W'(word_reg) << MB_W)
                              + PA_W'(first_one64(MAP_WORD_MAX'(map_cur)));
                    rpage_next = (PA_W'(grp_reg) << PG_W) + (PA_W'(word_reg) << MB_W)
                               + PA_W'(first_one64(MAP_WORD_MAX'(map_cur)));
                    pr_re = 1'b1;
                    pr_ra = (PA_W'(grp_reg) << PG_W) + (PA_W'(word_reg) << MB_W)
                          + PA_W'(first_one64(MAP_WORD_MAX'(map_cur)));
                    gu_re = 1'b1;
                    gu_ra = grp_reg;
                    state_next = S_MOD;
                end else if (word_reg == WW'(WPG - 1)) begin
                    st_next    = ST_NO_MEM;
                    state_next = S_DONE;
                end else begin
                    word_next = word_reg + 1'b1;
                    map_re    = 1'b1;
                    map_ra    = (MA_W'(grp_reg) << WSH) + MA_W'(word_reg + 1'b1);
                end
            end
            S_MOD:
            begin
                state_next = S_DONE;
                map_wa = MA_W'(page_reg >> MB_W);
                pr_wa  = page_reg;
                gu_wa  = grp_reg;
                gr_wa  = grp_reg;
                case (func_reg)
                    FN_ALLOC_PAGE:
                    begin
                        if (pr_rd == REF_MAX) begin
                            st_next = ST_SATURATED;
                        end else begin
                            pr_we = 1'b1;
                            pr_wd = pr_rd + 1'b1;
                            // first reference takes the page out of the free map
                            if (pr_rd == '0) begin
                                used_new = gu_rd + 1'b1;
                                map_we = 1'b1;
                                map_wd = map_cur & ~(MAP_W'(1) << bit_sel);
                                gu_we  = 1'b1;
                                gu_wd  = used_new;
                                nz_vec_next[grp_reg]   = 1'b1;
                                full_vec_next[grp_reg] = (32'(used_new) == PAGES_PER_GROUP);
                                free_cnt_next  = free_cnt_reg - 1'b1;
                                small_cnt_next = small_cnt_reg + 1'b1;
                            end
                        end
                    end
                    FN_FREE_PAGE:
                    begin
                        if (map_cur[bit_sel]) begin
                            st_next = ST_DBL_FREE;
                        end else begin
                            if (pr_rd != '0) begin
                                pr_we = 1'b1;
                                pr_wd = pr_rd - 1'b1;
                            end
                            if (pr_rd <= REF_WIDTH'(1)) begin
                                used_new = gu_rd - 1'b1;
                                map_we = 1'b1;
                                map_wd = map_cur | (MAP_W'(1) << bit_sel);
                                gu_we  = 1'b1;
                                gu_wd  = used_new;
                                nz_vec_next[grp_reg]   = (used_new != '0);
                                full_vec_next[grp_reg] = 1'b0;
                                free_cnt_next  = free_cnt_reg + 1'b1;
                                small_cnt_next = small_cnt_reg - 1'b1;
                            end
                        end
                    end
                    FN_ALLOC_HUGE:
                    begin
                        if (gr_rd == REF_MAX) begin
                            st_next = ST_SATURATED;
                        end else begin
                            gr_we = 1'b1;
                            gr_wd = gr_rd + 1'b1;
                            huge_vec_next[grp_reg] = 1'b1;
                            free_cnt_next = free_cnt_reg - CNT_W'(PAGES_PER_GROUP);
                            huge_cnt_next = huge_cnt_reg + 1'b1;
                            rpage_next    = PA_W'(grp_reg) << PG_W;
                        end
                    end
                    FN_FREE_HUGE:
                    begin
                        if (gr_rd != '0) begin
                            gr_we = 1'b1;
                            gr_wd = gr_rd - 1'b1;
                        end
                        if (gr_rd <= REF_WIDTH'(1)) begin
                            huge_vec_next[grp_reg] = 1'b0;
                            free_cnt_next = free_cnt_reg + CNT_W'(PAGES_PER_GROUP);
                            huge_cnt_next = huge_cnt_reg - 1'b1;
                        end
                    end
                    FN_ADD_REF:
                    begin
                        if (pr_rd == REF_MAX) begin
                            st_next = ST_SATURATED;
                        end else begin
                            pr_we = 1'b1;
                            pr_wd = pr_rd + 1'b1;
                        end
                    end
                    FN_DROP_REF:
                    begin
                        if (pr_rd == '0) begin
                            st_next = ST_UNDERFLOW;
                        end else begin
                            pr_we = 1'b1;
                            pr_wd = pr_rd - 1'b1;
                        end
                    end
                    FN_ADD_HREF:
                    begin
                        if (gr_rd == REF_MAX) begin
                            st_next = ST_SATURATED;
                        end else begin
                            gr_we = 1'b1;
                            gr_wd = gr_rd + 1'b1;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_DONE:
            begin
                // hold the finished beat until the output register is free
                if (!ov_reg || out_ready) begin
                    ov_next      = 1'b1;
                    o_page_next  = 15'(rpage_reg);
                    o_st_next    = st_reg;
                    o_free_next  = 16'(free_cnt_reg);
                    o_small_next = 16'(small_cnt_reg);
                    o_huge_next  = 7'(huge_cnt_reg);
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            free_cnt_reg  <= CNT_W'(TOTAL);
            small_cnt_reg <= '0;
            huge_cnt_reg  <= '0;
            huge_vec_reg  <= '0;
            nz_vec_reg    <= '0;
            full_vec_reg  <= '0;
            ov_reg        <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            free_cnt_reg  <= free_cnt_next;
            small_cnt_reg <= small_cnt_next;
            huge_cnt_reg  <= huge_cnt_next;
            huge_vec_reg  <= huge_vec_next;
            nz_vec_reg    <= nz_vec_next;
            full_vec_reg  <= full_vec_next;
            ov_reg        <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg    <= func_next;
        page_reg    <= page_next;
        rpage_reg   <= rpage_next;
        grp_reg     <= grp_next;
        pv_reg      <= pv_next;
        gv_reg      <= gv_next;
        word_reg    <= word_next;
        st_reg      <= st_next;
        o_page_reg  <= o_page_next;
        o_st_reg    <= o_st_next;
        o_free_reg  <= o_free_next;
        o_small_reg <= o_small_next;
        o_huge_reg  <= o_huge_next;
    end
endmodule
`default_nettype wire

[rtl/core/tpa_checker.sv]
// port-level assertions for the page allocator, bound to the top level
`default_nettype none
module tpa_checker #(
    parameter int PAGES_PER_GROUP = 512,
    parameter int NUM_GROUPS      = 64
) (
    input wire        clk,
    input wire        rst_n,
    input wire        in_valid,
    input wire        in_ready,
    input wire        out_valid,
    input wire        out_ready,
    input wire [14:0] result_page,
    input wire [2:0]  status,
    input wire [15:0] free_pages,
    input wire [15:0] used_small,
    input wire [6:0]  used_huge
);
    import tpa_pkg::*;

    // one item in flight: no new beat right after an accept
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while an item is in flight");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(result_page) && $stable(status))
        else $error("result beat changed while stalled");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status <= 3'(ST_SATURATED))
        else $error("status code out of range");

    // every page is free, small-allocated or inside a huge group
    a_conserve: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (32'(free_pages) + 32'(used_small) + 32'(used_huge) * PAGES_PER_GROUP
                       == (PAGES_PER_GROUP * NUM_GROUPS) % 65536 + 0))
        else $error("page counts do not add up");

    a_oom_page: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == 3'(ST_NO_MEM) |-> result_page == 15'd0)
        else $error("page returned with out of memory");
endmodule

bind two_level_page_allocator_unit tpa_checker #(
    .PAGES_PER_GROUP(PAGES_PER_GROUP),
    .NUM_GROUPS     (NUM_GROUPS)
) u_tpa_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .result_page(result_page),
    .status(status), .free_pages(free_pages), .used_small(used_small),
    .used_huge(used_huge)
);
`default_nettype wire
